// File: design/container_checksum_md5_variant_assert.svh
// Assertion macros shared by the checksum RTL
`ifndef CONTAINER_CHECKSUM_MD5_VARIANT_ASSERT_SVH
`define CONTAINER_CHECKSUM_MD5_VARIANT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define CCM_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the condition
`define CCM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: design/ccmd5_pkg.sv
`timescale 1ns / 1ps
package ccmd5_pkg;

   localparam int unsigned HdrSkip = 20;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_rot(input logic [5:0] i);
      logic [4:0] r;
      unique case ({i[5:4], i[1:0]})
         4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
         4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
         4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
         4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
   endfunction

   // message word index for round i
   function automatic logic [3:0] md5_g(input logic [5:0] i);
      logic [3:0] g;
      logic [3:0] l;
      l = i[3:0];
      unique case (i[5:4])
         2'd0: g = l;
         2'd1: g = 4'(5 * l + 1);
         2'd2: g = 4'(3 * l + 5);
         default: g = 4'(7 * l);
      endcase
      return g;
   endfunction

   typedef struct packed {
      logic start;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } ccmd5_start_type;

endpackage

// File: design/container_checksum_md5_variant.sv
`timescale 1ns / 1ps
// Modified-MD5 container checksum.
// req_ channel: one container byte per transfer (req_data_byte), req_last on
// the final byte. The first 20 bytes are skipped; each further 64 bytes are
// compressed with MD5 and the last byte closes the hash with the container's
// own final block layout.
// rsp_ channel: four transfers per container, chaining word A to D, with
// rsp_word_index, rsp_last_word on D and rsp_too_short if fewer than 20 bytes
// came (the words are then zero, offered the cycle after the last byte).
// Throughput: a byte per cycle while a block fills; after the 64th byte of a
// block req_ready stays low while the block fetches the first word, starts the
// round unit, runs the 64 rounds, raises the done flag and adds.
// Closing takes one or two such compressions, preceded by a write of the part
// word of the tail when the last byte does not complete a word. The words go
// one per cycle; a stalled receiver holds the current word and the block takes
// no new byte until all four have gone.
// Reset (synchronous, active high) loads the MD5 initial values and clears
// the counters; the byte store needs no clearing. After each container the
// block returns to that state by itself.
module container_checksum_md5_variant
   import ccmd5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_too_short
);
`include "container_checksum_md5_variant_assert.svh"

   typedef enum logic [2:0] {
      ST_LOAD, ST_FETCH, ST_RUN, ST_ADD, ST_EMIT
   } state_type;

   // word-wide store of the current block, one write and one read port
   logic [31:0] mem [16];
   logic [31:0] rd_data_ff;

   state_type   state_ff;
   logic [31:0] ha_ff, hb_ff, hc_ff, hd_ff;
   logic [31:0] count_ff;
   logic [4:0]  hdr_ff;
   logic [1:0]  phase_ff;   // 0 data block, 1 closing block, 2 second closing block
   logic        short_ff;
   logic [1:0]  idx_ff;
   logic [31:0] anum_ff, bnum_ff;
   logic [5:0]  rem_ff;
   logic [31:0] word_ff;    // assembly of the word being loaded
   logic        mem_tail_pending;
   logic        last_pending_ff;

   ccmd5_start_type ctl;
   logic [5:0]  round;
   logic        busy, done;
   logic [31:0] ra, rb, rc, rd;
   logic [3:0]  rd_addr;
   logic [31:0] m_word;

   ccmd5_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl), .m_word(m_word),
      .round(round), .busy(busy), .done(done),
      .h_a(ra), .h_b(rb), .h_c(rc), .h_d(rd)
   );

   logic        acc;
   logic [5:0]  pos;
   logic [31:0] wnext;
   logic        in_hdr;
   assign acc    = req_valid && req_ready;
   assign pos    = count_ff[5:0];
   assign in_hdr = hdr_ff < 5'(HdrSkip);

   always_comb begin
      wnext = word_ff;
      unique case (pos[1:0])
         2'd0: wnext[7:0]   = req_data_byte;
         2'd1: wnext[15:8]  = req_data_byte;
         2'd2: wnext[23:16] = req_data_byte;
         default: wnext[31:24] = req_data_byte;
      endcase
   end

   // closing block word w from stored tail word
   function automatic logic [31:0] close_word(input logic [1:0] ph, input logic [3:0] w,
                                              input logic [31:0] raw, input logic [5:0] r,
                                              input logic [31:0] an, input logic [31:0] bn);
      logic [31:0] o;
      logic [5:0]  base;
      logic [6:0]  bp;
      o = '0;
      if (ph == 2'd2) begin
         if (w == 4'd0) o = an;
         else if (w == 4'd15) o = bn;
      end else if (r >= 6'd56) begin
         for (int j = 0; j < 4; j++) begin
            bp = {1'b0, w, 2'(j)};
            if (bp < {1'b0, r}) o[8*j +: 8] = raw[8*j +: 8];
            else if (bp == {1'b0, r}) o[8*j +: 8] = 8'h80;
         end
      end else begin
         if (w == 4'd0) o = an;
         else if (w == 4'd15) o = bn;
         else begin
            // bytes 4.. hold tail; byte p comes from tail byte p-4
            base = 6'({w, 2'b00} - 6'd4);
            for (int j = 0; j < 4; j++) begin
               bp = {1'b0, base} + 7'(j);
               if (bp < {1'b0, r}) o[8*j +: 8] = raw[8*j +: 8];
               else if (bp == {1'b0, r}) o[8*j +: 8] = 8'h80;
            end
         end
      end
      return o;
   endfunction

   // for the short-tail block, word w uses stored word w-1 (shift by one word)
   always_comb begin
      logic [3:0] g;
      g = (round == 6'd63 || !busy) ? 4'd0 : md5_g(round + 6'd1);
      if (state_ff == ST_FETCH) g = 4'd0;
      if (phase_ff == 2'd1 && rem_ff < 6'd56) rd_addr = g - 4'd1;
      else rd_addr = g;
   end

   logic [3:0] cur_g;
   assign cur_g = md5_g(round);
   assign m_word = (phase_ff == 2'd0) ? rd_data_ff :
                   close_word(phase_ff, cur_g, rd_data_ff, rem_ff, anum_ff, bnum_ff);

   // a part word of the tail is written in the cycle after the last byte
   always_ff @(posedge clock) begin
      if (acc && !in_hdr && pos[1:0] == 2'd3) mem[pos[5:2]] <= wnext;
      else if (state_ff == ST_FETCH && mem_tail_pending) mem[rem_ff[5:2]] <= word_ff;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      ctl.start <= !reset && (state_ff == ST_FETCH) && !mem_tail_pending;
      if (reset) begin
         state_ff <= ST_LOAD;
         ha_ff <= InitA; hb_ff <= InitB; hc_ff <= InitC; hd_ff <= InitD;
         count_ff <= '0;
         hdr_ff <= '0;
         phase_ff <= '0;
         short_ff <= 1'b0;
         idx_ff <= '0;
         mem_tail_pending <= 1'b0;
         last_pending_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: if (acc) begin
               word_ff <= wnext;
               if (in_hdr) begin
                  hdr_ff <= hdr_ff + 5'd1;
                  if (req_last) begin
                     short_ff <= (hdr_ff + 5'd1) < 5'(HdrSkip);
                     if ((hdr_ff + 5'd1) < 5'(HdrSkip)) begin
                        idx_ff <= '0;
                        state_ff <= ST_EMIT;
                     end else begin
                        phase_ff <= 2'd1;
                        state_ff <= ST_FETCH;
                     end
                  end
               end else begin
                  count_ff <= count_ff + 32'd1;
                  if (pos == 6'd63) begin
                     phase_ff <= 2'd0;
                     state_ff <= ST_FETCH;
                  end else if (req_last) begin
                     phase_ff <= 2'd1;
                     state_ff <= ST_FETCH;
                  end
               end
               // partial word of a tail goes to store too
               if (!in_hdr && req_last && pos[1:0] != 2'd3) mem_tail_pending <= 1'b1;
               anum_ff  <= (in_hdr ? count_ff : count_ff + 32'd1) << 3;
               bnum_ff  <= (((in_hdr ? count_ff : count_ff + 32'd1) << 3) >> 2) | 32'd1;
               rem_ff   <= in_hdr ? pos : pos + 6'd1;
               last_pending_ff <= req_last;
            end
            ST_FETCH: begin
               if (mem_tail_pending) begin
                  mem_tail_pending <= 1'b0;
               end else begin
                  ctl.a <= ha_ff; ctl.b <= hb_ff; ctl.c <= hc_ff; ctl.d <= hd_ff;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: if (done) begin
               ha_ff <= ha_ff + ra; hb_ff <= hb_ff + rb;
               hc_ff <= hc_ff + rc; hd_ff <= hd_ff + rd;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               if (phase_ff == 2'd0) begin
                  if (last_pending_ff) begin
                     phase_ff <= 2'd1;
                     state_ff <= ST_FETCH;
                  end else state_ff <= ST_LOAD;
               end else if (phase_ff == 2'd1 && rem_ff >= 6'd56) begin
                  phase_ff <= 2'd2;
                  state_ff <= ST_FETCH;
               end else begin
                  idx_ff <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            default: if (rsp_ready) begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_ff <= ST_LOAD;
                  ha_ff <= InitA; hb_ff <= InitB; hc_ff <= InitC; hd_ff <= InitD;
                  count_ff <= '0;
                  hdr_ff <= '0;
                  short_ff <= 1'b0;
                  phase_ff <= '0;
               end
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   always_comb begin
      unique case (idx_ff)
         2'd0: rsp_digest_word = ha_ff;
         2'd1: rsp_digest_word = hb_ff;
         2'd2: rsp_digest_word = hc_ff;
         default: rsp_digest_word = hd_ff;
      endcase
      if (short_ff) rsp_digest_word = '0;
   end
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == 2'd3);
   assign rsp_too_short  = short_ff;

   `CCM_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready,
      "input accepted while digest pending")
   `CCM_ASSERT_NEXT(a_emit_done, clock, reset, rsp_valid && rsp_ready && rsp_last_word,
      req_ready && !rsp_valid, "block did not return to loading")
   `CCM_ASSERT_IMPL(a_short_first, clock, reset, rsp_too_short && rsp_valid,
      rsp_digest_word == 32'd0, "short container gave nonzero word")
endmodule

// File: design/ccmd5_round.sv
`timescale 1ns / 1ps
module ccmd5_round
   import ccmd5_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ccmd5_start_type ctl,
   input  logic [31:0]     m_word,
   output logic [5:0]      round,
   output logic            busy,
   output logic            done,
   output logic [31:0]     h_a,
   output logic [31:0]     h_b,
   output logic [31:0]     h_c,
   output logic [31:0]     h_d
);
   // one MD5 round per cycle; m_word is the message word md5_g(round)
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] f, sum, rot;
   logic [5:0]  round_ff;
   logic        busy_ff, done_ff;

   always_comb begin
      unique case (round_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f + md5_k(round_ff) + m_word;
      rot = (sum << md5_rot(round_ff)) | (sum >> (6'd32 - {1'b0, md5_rot(round_ff)}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         done_ff <= busy_ff && !ctl.start && (round_ff == 6'd63);
         if (ctl.start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
            a_ff <= ctl.a; b_ff <= ctl.b; c_ff <= ctl.c; d_ff <= ctl.d;
         end else if (busy_ff) begin
            a_ff <= d_ff;
            d_ff <= c_ff;
            c_ff <= b_ff;
            b_ff <= b_ff + rot;
            round_ff <= round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign round = round_ff;
   assign busy  = busy_ff;
   assign done  = done_ff;
   assign h_a = a_ff;
   assign h_b = b_ff;
   assign h_c = c_ff;
   assign h_d = d_ff;
endmodule
